// ===== src/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants for the round-robin task scheduler
// Payload words, command and status codes, register indexes and the
// request/response bundle of the remainder unit.
// ----------------------------------------------------------------------------
package prr_pkg;

  // Default depth of the process table
  localparam int unsigned MAX_PROCESSES_DEF = 16;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int PRIO_W   = 8;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 32;
  localparam int LOCK_W   = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [LOCK_W-1:0] LOCK_MAX = {LOCK_W{1'b1}};

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SPAWN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNLOCK = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOCUR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_IDLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_DEFAULT  = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_IDLE_RST     = 8'd1;
  localparam logic [PRIO_W-1:0] PRIO_CRITICAL_RST = 8'd4;
  localparam logic [PRIO_W-1:0] PRIO_DEFAULT_RST  = 8'd2;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] priority_req;
  } prr_in_t;

  // Result word
  typedef struct packed {
    logic                running_valid;
    logic [ID_W-1:0]     running_slot;
    logic [ID_W-1:0]     running_pid;
    logic                switched;
    logic                locked_now;
    logic [STATUS_W-1:0] status;
  } prr_out_t;

  // Remainder unit request and response
  typedef struct packed {
    logic               start;
    logic [FRAME_W-1:0] dividend;
    logic [PRIO_W-1:0]  divisor;
  } prr_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PRIO_W-1:0] rem;
  } prr_div_rsp_t;

endpackage

// ===== src/prr_rem.sv =====
// ----------------------------------------------------------------------------
// prr_rem: serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder of a
// 32-bit frame count by an 8-bit nonzero priority and pulses done.
// ----------------------------------------------------------------------------
module prr_rem
  import prr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  prr_div_req_t req,
  output prr_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(FRAME_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FRAME_W-1:0] dvd_r;
  logic [PRIO_W-1:0]  div_r;
  logic [PRIO_W-1:0]  rem_r;
  logic [PRIO_W:0]    trial;
  logic [PRIO_W:0]    diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, dvd_r[FRAME_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAME_W - 1);
        dvd_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // Keep the difference when it does not borrow
        if (trial >= {1'b0, div_r}) begin
          rem_r <= diff[PRIO_W-1:0];
        end else begin
          rem_r <= trial[PRIO_W-1:0];
        end
        dvd_r <= {dvd_r[FRAME_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/priority_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler: round-robin task scheduler with priorities
// Keeps a table of process slots linked in spawn order and answers each
// command word with one status word about the current process.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_stall/in_data carries one command word (tick,
//   spawn, exit, lock, unlock). Every word yields exactly one result word on
//   out_valid/out_stall/out_data. The configuration port cfg_valid/cfg_ready
//   writes the three priority limits; it is always ready and should only be
//   written while the block is idle.
//   Commands are handled one at a time by a small sequencer over the slot
//   memories; in_stall stays high until the result is loaded into the output
//   register. Lock, unlock, unused codes and locked or empty ticks go straight
//   to the pid fetch; a tick right after an exit or with no current process
//   first picks the next slot; a running tick waits for the serial remainder
//   unit; spawn scans the slots, then searches a pid over a taken bitmap; exit
//   walks the links to the predecessor of the current slot.
//   A result stalled by the receiver holds in the output register; the next
//   word is accepted meanwhile and finishes once the register frees up.
//   Reset (rst_n low, synchronous) empties the table and restores the
//   default priority limits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler
  import prr_pkg::*;
#(
  parameter int unsigned MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PRIO_W-1:0]    cfg_data
);

  localparam int SW = $clog2(MAX_PROCESSES);
  localparam int CW = SW + 1;
  localparam logic [CW-1:0] IDX_END = CW'(MAX_PROCESSES);

  typedef enum logic [3:0] {
    S_IDLE, S_TK_GO, S_TK_DIV, S_TK_SEL,
    S_SP_SCAN, S_SP_PID, S_SP_WR, S_SP_LINK,
    S_EX_START, S_EX_RD, S_EX_STEP, S_EX_FIN,
    S_PID, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [PRIO_W-1:0] prio_idle_r, prio_idle_nxt;
  logic [PRIO_W-1:0] prio_crit_r, prio_crit_nxt;
  logic [PRIO_W-1:0] prio_dflt_r, prio_dflt_nxt;

  // Scheduler state
  logic [MAX_PROCESSES-1:0] used_r, used_nxt;
  logic [SW-1:0]      head_r, head_nxt;
  logic [SW-1:0]      tail_r, tail_nxt;
  logic               nonempty_r, nonempty_nxt;
  logic [SW-1:0]      cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               died_r, died_nxt;
  logic [LOCK_W-1:0]  lock_r, lock_nxt;

  // Sequencer working registers
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     chk_v_r, chk_v_nxt;
  logic [SW-1:0]            chk_s_r, chk_s_nxt;
  logic [MAX_PROCESSES-1:0] taken_r, taken_nxt;
  logic                     found_r, found_nxt;
  logic [SW-1:0]            free_r, free_nxt;
  logic [PRIO_W-1:0]        prio_sel_r, prio_sel_nxt;
  logic [SW-1:0]            n_r, n_nxt;
  logic [SW-1:0]            p_r, p_nxt;
  logic [CW-1:0]            steps_r, steps_nxt;
  logic                     was_tail_r, was_tail_nxt;
  logic                     old_v_r, old_v_nxt;
  logic [SW-1:0]            old_s_r, old_s_nxt;
  logic                     sw_r, sw_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  // Output register
  logic     out_valid_r, out_valid_nxt;
  prr_out_t out_data_r, out_data_nxt;

  // Slot memories
  logic [SW-1:0]     pid_mem  [MAX_PROCESSES];
  logic [PRIO_W-1:0] prio_mem [MAX_PROCESSES];
  logic [SW-1:0]     link_mem [MAX_PROCESSES];
  logic [SW-1:0]     pid_q;
  logic [PRIO_W-1:0] prio_q;
  logic [SW-1:0]     link_q;
  logic [SW-1:0]     mem_ra;
  logic              slot_we;
  logic              link_we;
  logic [SW-1:0]     link_wa;
  logic [SW-1:0]     link_wd;

  // Remainder unit, used only by the tick
  prr_div_req_t div_req;
  prr_div_rsp_t div_rsp;
  logic [SW-1:0] sel_slot;

  prr_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    prio_idle_nxt = prio_idle_r;
    prio_crit_nxt = prio_crit_r;
    prio_dflt_nxt = prio_dflt_r;
    used_nxt      = used_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    frame_nxt     = frame_r;
    died_nxt      = died_r;
    lock_nxt      = lock_r;
    idx_nxt       = idx_r;
    chk_v_nxt     = chk_v_r;
    chk_s_nxt     = chk_s_r;
    taken_nxt     = taken_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    prio_sel_nxt  = prio_sel_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    steps_nxt     = steps_r;
    was_tail_nxt  = was_tail_r;
    old_v_nxt     = old_v_r;
    old_s_nxt     = old_s_r;
    sw_nxt        = sw_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    // Drop the result once the receiver takes it
    out_valid_nxt = out_valid_r && out_stall;
    mem_ra        = cur_r;
    slot_we       = 1'b0;
    link_we       = 1'b0;
    link_wa       = free_r;
    link_wd       = free_r;
    div_req       = '0;
    sel_slot      = cur_valid_r ? cur_r : head_r;

    // Register writes
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRIO_IDLE:     prio_idle_nxt = cfg_data;
        CFG_PRIO_CRITICAL: prio_crit_nxt = cfg_data;
        CFG_PRIO_DEFAULT:  prio_dflt_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          sw_nxt     = 1'b0;
          old_v_nxt  = cur_valid_r;
          old_s_nxt  = cur_r;
          state_nxt  = S_PID;
          unique case (in_data.mode)
            MODE_TICK: begin
              if (lock_r != '0) begin
                state_nxt = S_PID;
              end else if (!nonempty_r) begin
                status_nxt = ST_EMPTY;
              end else if (cur_valid_r && !died_r) begin
                state_nxt = S_TK_GO;
              end else begin
                state_nxt = S_TK_SEL;
              end
            end
            MODE_SPAWN: begin
              if (in_data.priority_req > prio_crit_r || in_data.priority_req < prio_idle_r) begin
                prio_sel_nxt = prio_dflt_r;
              end else begin
                prio_sel_nxt = in_data.priority_req;
              end
              idx_nxt   = '0;
              chk_v_nxt = 1'b0;
              taken_nxt = '0;
              found_nxt = 1'b0;
              state_nxt = S_SP_SCAN;
            end
            MODE_EXIT: begin
              if (!cur_valid_r || !nonempty_r) begin
                status_nxt = ST_NOCUR;
              end else begin
                state_nxt = S_EX_START;
              end
            end
            MODE_LOCK: begin
              if (lock_r != LOCK_MAX) lock_nxt = lock_r + 1'b1;
            end
            MODE_UNLOCK: begin
              if (lock_r != '0) lock_nxt = lock_r - 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Start the remainder of the frame count by the current priority
      S_TK_GO: begin
        n_nxt            = link_q;
        div_req.start    = 1'b1;
        div_req.dividend = frame_r;
        div_req.divisor  = (prio_q == '0) ? PRIO_W'(1) : prio_q;
        state_nxt        = S_TK_DIV;
      end

      // Advance on a zero remainder, then count the frame
      S_TK_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            if (cur_r == tail_r) begin
              cur_valid_nxt = 1'b0;
              cur_nxt       = '0;
            end else begin
              cur_nxt = n_r;
            end
          end
          frame_nxt = frame_r + 1'b1;
          state_nxt = S_TK_SEL;
        end
      end

      // Wrap to the head when no process is current
      S_TK_SEL: begin
        cur_nxt       = sel_slot;
        cur_valid_nxt = 1'b1;
        died_nxt      = 1'b0;
        sw_nxt        = !old_v_r || (old_s_r != sel_slot);
        state_nxt     = S_PID;
      end

      // Scan slots: first free slot and bitmap of live pids
      S_SP_SCAN: begin
        mem_ra = idx_r[SW-1:0];
        if (chk_v_r) begin
          if (used_r[chk_s_r]) begin
            taken_nxt[pid_q] = 1'b1;
          end else if (!found_r) begin
            found_nxt = 1'b1;
            free_nxt  = chk_s_r;
          end
        end
        if (idx_r == IDX_END) begin
          chk_v_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_SP_PID;
        end else begin
          chk_v_nxt = 1'b1;
          chk_s_nxt = idx_r[SW-1:0];
          idx_nxt   = idx_r + 1'b1;
        end
      end

      // Search the smallest pid not taken
      S_SP_PID: begin
        if (!found_r) begin
          status_nxt = ST_FULL;
          state_nxt  = S_PID;
        end else if (taken_r[idx_r[SW-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_SP_WR;
        end
      end

      // Fill the new slot and make it self-linked
      S_SP_WR: begin
        slot_we            = 1'b1;
        link_we            = 1'b1;
        used_nxt[free_r]   = 1'b1;
        if (nonempty_r) begin
          state_nxt = S_SP_LINK;
        end else begin
          head_nxt     = free_r;
          tail_nxt     = free_r;
          nonempty_nxt = 1'b1;
          state_nxt    = S_PID;
        end
      end

      // Append behind the old tail
      S_SP_LINK: begin
        link_we   = 1'b1;
        link_wa   = tail_r;
        tail_nxt  = free_r;
        state_nxt = S_PID;
      end

      // Unlink the current process; head case needs no walk
      S_EX_START: begin
        n_nxt        = link_q;
        was_tail_nxt = (cur_r == tail_r);
        if (cur_r == head_r) begin
          if (cur_r == tail_r) begin
            nonempty_nxt = 1'b0;
          end else begin
            head_nxt = link_q;
          end
          state_nxt = S_EX_FIN;
        end else begin
          p_nxt     = head_r;
          steps_nxt = '0;
          state_nxt = S_EX_RD;
        end
      end

      S_EX_RD: begin
        mem_ra    = p_r;
        state_nxt = S_EX_STEP;
      end

      // Walk to the predecessor, then bridge over the current slot
      S_EX_STEP: begin
        mem_ra = p_r;
        if (link_q != cur_r && p_r != tail_r && steps_r != IDX_END) begin
          p_nxt     = link_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_EX_RD;
        end else begin
          link_we = 1'b1;
          link_wa = p_r;
          link_wd = n_r;
          if (was_tail_r) tail_nxt = p_r;
          state_nxt = S_EX_FIN;
        end
      end

      S_EX_FIN: begin
        used_nxt[cur_r] = 1'b0;
        if (was_tail_r || !nonempty_r) begin
          cur_valid_nxt = 1'b0;
          cur_nxt       = '0;
        end else begin
          cur_nxt = n_r;
        end
        died_nxt  = 1'b1;
        state_nxt = S_PID;
      end

      // Fetch the pid of the current slot
      S_PID: begin
        state_nxt = S_FIN;
      end

      // Load the result once the output register is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.running_valid = cur_valid_r;
          out_data_nxt.running_slot  = cur_valid_r ? ID_W'(cur_r) : '0;
          out_data_nxt.running_pid   = cur_valid_r ? ID_W'(pid_q) : '0;
          out_data_nxt.switched      = sw_r;
          out_data_nxt.locked_now    = (lock_r != '0);
          out_data_nxt.status        = status_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prio_idle_r <= PRIO_IDLE_RST;
      prio_crit_r <= PRIO_CRITICAL_RST;
      prio_dflt_r <= PRIO_DEFAULT_RST;
      used_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      frame_r     <= '0;
      died_r      <= 1'b0;
      lock_r      <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prio_idle_r <= prio_idle_nxt;
      prio_crit_r <= prio_crit_nxt;
      prio_dflt_r <= prio_dflt_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      frame_r     <= frame_nxt;
      died_r      <= died_nxt;
      lock_r      <= lock_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    chk_s_r    <= chk_s_nxt;
    taken_r    <= taken_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    prio_sel_r <= prio_sel_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    steps_r    <= steps_nxt;
    was_tail_r <= was_tail_nxt;
    old_v_r    <= old_v_nxt;
    old_s_r    <= old_s_nxt;
    sw_r       <= sw_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (slot_we) begin
      pid_mem[free_r]  <= idx_r[SW-1:0];
      prio_mem[free_r] <= prio_sel_r;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    pid_q  <= pid_mem[mem_ra];
    prio_q <= prio_mem[mem_ra];
    link_q <= link_mem[mem_ra];
  end

  // A current process between commands is a live slot of a nonempty list
  a_cur_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cur_valid_r) |-> (nonempty_r && used_r[cur_r]))
    else $error("current process is not a live slot");

  // Head and tail of a nonempty list are live slots
  a_ends_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && nonempty_r) |-> (used_r[head_r] && used_r[tail_r]))
    else $error("list end points at a free slot");

  // The remainder unit only finishes while a tick waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_TK_DIV))
    else $error("remainder result outside a tick");

endmodule
